FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Both macros sample on the rising edge of clock and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// When the trigger holds, the consequence must hold at the same edge.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

FILE: sv/gnp_pkg.sv
package gnp_pkg;

   // Request and response channel widths.
   localparam int CMD_W      = 2;
   localparam int IN_COORD_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int OUT_IDX_W  = 13;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // Request kinds carried on req_tuser.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_PAIR  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_MARK   = 5'b10000
   } state_type;

endpackage

FILE: sv/gnp_dist.sv
module gnp_dist #(
   parameter int COORD_BITS = 16,
   parameter int IDX_W      = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [IDX_W-1:0]      in_idx,
   input  logic [COORD_BITS-1:0] pt_x,
   input  logic [COORD_BITS-1:0] pt_y,
   input  logic [COORD_BITS-1:0] anc_x,
   input  logic [COORD_BITS-1:0] anc_y,
   output logic                  out_vld,
   output logic [IDX_W-1:0]      out_idx,
   output logic [2*COORD_BITS:0] out_dist,
   output logic                  busy
);

   localparam int SQ_W = 2 * COORD_BITS;

   logic                  s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic [IDX_W-1:0]      s2_idx_ff, s2_idx_in;
   logic [SQ_W-1:0]       sqx_ff, sqx_in;
   logic [SQ_W-1:0]       sqy_ff, sqy_in;

   // First stage: absolute coordinate differences to the anchor.
   always_comb begin
      s1_vld_in = in_vld;
      s1_idx_in = in_idx;
      dx_in     = (pt_x >= anc_x) ? (pt_x - anc_x) : (anc_x - pt_x);
      dy_in     = (pt_y >= anc_y) ? (pt_y - anc_y) : (anc_y - pt_y);
   end

   // Second stage: one square per axis.
   always_comb begin
      s2_vld_in = s1_vld_ff;
      s2_idx_in = s1_idx_ff;
      sqx_in    = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_in    = SQ_W'(dy_ff) * SQ_W'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
      s1_idx_ff <= s1_idx_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      s2_idx_ff <= s2_idx_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
   end

   // The sum of squares feeds the compare against the best distance so far.
   assign out_vld  = s2_vld_ff;
   assign out_idx  = s2_idx_ff;
   assign out_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign busy     = s1_vld_ff | s2_vld_ff;

endmodule

FILE: sv/greedy_nearest_pairing.sv
// Greedy nearest pairing engine over a point memory of MAX_POINTS entries.
// Load and clear requests leave the engine idle, so it is ready again the next cycle.
// A pair request holds the input off until the engine is idle again, plus any wait for
// the response channel: the scan reads one point a cycle from the point memory's single
// read port, then a drain, the finish and, when a partner was found, the mark.
// Synchronous reset clears the point count and control state at once, with no clearing pass;
// memory contents stay undefined and are only read below the count after a fresh load.
`include "assert_macros.svh"

module greedy_nearest_pairing #(
   parameter int MAX_POINTS = 8192,
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // coord_x [15:0], coord_y [31:16]
   input  logic [gnp_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [gnp_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // first_index [12:0], partner_index [25:13], zero fill [31:26]
   output logic [gnp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // alone [0], empty_res [1]
   output logic [gnp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import gnp_pkg::*;

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DIST_W = 2 * COORD_BITS + 1;
   localparam int PT_W   = 2 * COORD_BITS;
   localparam int FILL_W = RSP_DATA_W - 2 * OUT_IDX_W;

   // Point memory holds {y, x}; the paired map is a separate one-bit memory.
   logic [PT_W-1:0] pt_mem   [MAX_POINTS];
   logic            pair_mem [MAX_POINTS];

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_cnt_ff, scan_cnt_in;

   logic [PT_W-1:0]       pt_rd_ff;
   logic                  pair_rd_ff;
   logic                  rd_vld_ff;
   logic [IDX_W-1:0]      rd_idx_ff;

   logic                  anchor_found_ff, anchor_found_in;
   logic [IDX_W-1:0]      anchor_idx_ff, anchor_idx_in;
   logic [COORD_BITS-1:0] anc_x_ff, anc_x_in;
   logic [COORD_BITS-1:0] anc_y_ff, anc_y_in;
   logic                  partner_found_ff, partner_found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]     best_d_ff, best_d_in;

   logic                  rsp_vld_ff, rsp_vld_in;
   logic [OUT_IDX_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [OUT_IDX_W-1:0]  rsp_partner_ff, rsp_partner_in;
   logic                  rsp_alone_ff, rsp_alone_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  accept;
   cmd_type               req_cmd;
   logic [COORD_BITS-1:0] ld_x, ld_y;
   logic                  ld_en;
   logic [IDX_W-1:0]      ld_addr;
   logic                  issue;
   logic [IDX_W-1:0]      rd_addr;
   logic                  pw_en;
   logic [IDX_W-1:0]      pw_addr;
   logic                  pw_data;
   logic                  start;
   logic                  unpaired;
   logic                  take_anchor;
   logic                  cand_vld;
   logic                  dist_vld;
   logic [IDX_W-1:0]      dist_idx;
   logic [DIST_W-1:0]     dist_val;
   logic                  dist_busy;
   logic                  better;

   // Request decode; coordinates are cut or widened to COORD_BITS.
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign req_cmd    = cmd_type'(req_tuser);
   assign ld_x       = COORD_BITS'(req_tdata[IN_COORD_W-1:0]);
   assign ld_y       = COORD_BITS'(req_tdata[2*IN_COORD_W-1:IN_COORD_W]);
   assign ld_en      = accept && (req_cmd == CMD_LOAD) && (count_ff < CNT_W'(MAX_POINTS));
   assign ld_addr    = count_ff[IDX_W-1:0];

   // The scan issues one read a cycle for every index below the count.
   assign issue   = (state_ff == ST_SCAN) && (scan_cnt_ff != count_ff);
   assign rd_addr = scan_cnt_ff[IDX_W-1:0];

   // Point memory. Loads happen only while idle and the scan only while busy,
   // so a write and a read never meet on one entry.
   always_ff @(posedge clock) begin
      if (ld_en) begin
         pt_mem[ld_addr] <= {ld_y, ld_x};
      end
      if (issue) begin
         pt_rd_ff <= pt_mem[rd_addr];
      end
   end

   // Paired map. Each load clears its own entry, so a clear only resets the count.
   always_ff @(posedge clock) begin
      if (pw_en) begin
         pair_mem[pw_addr] <= pw_data;
      end
      if (issue) begin
         pair_rd_ff <= pair_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
      end
      rd_idx_ff <= rd_addr;
   end

   // The first unpaired point read becomes the anchor; later ones are candidates.
   assign unpaired    = rd_vld_ff && !pair_rd_ff;
   assign take_anchor = unpaired && !anchor_found_ff;
   assign cand_vld    = unpaired && anchor_found_ff;

   gnp_dist #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (cand_vld),
      .in_idx   (rd_idx_ff),
      .pt_x     (pt_rd_ff[COORD_BITS-1:0]),
      .pt_y     (pt_rd_ff[PT_W-1:COORD_BITS]),
      .anc_x    (anc_x_ff),
      .anc_y    (anc_y_ff),
      .out_vld  (dist_vld),
      .out_idx  (dist_idx),
      .out_dist (dist_val),
      .busy     (dist_busy)
   );

   // Strictly smaller distance wins, so ties keep the lower index seen first.
   assign better = dist_vld && (!partner_found_ff || (dist_val < best_d_ff));

   // Anchor and best-partner tracking.
   always_comb begin
      anchor_found_in  = anchor_found_ff;
      anchor_idx_in    = anchor_idx_ff;
      anc_x_in         = anc_x_ff;
      anc_y_in         = anc_y_ff;
      partner_found_in = partner_found_ff;
      best_idx_in      = best_idx_ff;
      best_d_in        = best_d_ff;
      if (start) begin
         anchor_found_in  = 1'b0;
         partner_found_in = 1'b0;
      end else begin
         if (take_anchor) begin
            anchor_found_in = 1'b1;
            anchor_idx_in   = rd_idx_ff;
            anc_x_in        = pt_rd_ff[COORD_BITS-1:0];
            anc_y_in        = pt_rd_ff[PT_W-1:COORD_BITS];
         end
         if (better) begin
            partner_found_in = 1'b1;
            best_idx_in      = dist_idx;
            best_d_in        = dist_val;
         end
      end
   end

   // Sequencer, count, paired-map writes and the response register.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_cnt_in    = scan_cnt_ff;
      start          = 1'b0;
      pw_en          = 1'b0;
      pw_addr        = anchor_idx_ff;
      pw_data        = 1'b1;
      rsp_vld_in     = rsp_vld_ff & ~rsp_tready;
      rsp_first_in   = rsp_first_ff;
      rsp_partner_in = rsp_partner_ff;
      rsp_alone_in   = rsp_alone_ff;
      rsp_empty_in   = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD: begin
                     if (ld_en) begin
                        count_in = count_ff + CNT_W'(1);
                        pw_en    = 1'b1;
                        pw_addr  = ld_addr;
                        pw_data  = 1'b0;
                     end
                  end
                  CMD_PAIR: begin
                     start       = 1'b1;
                     scan_cnt_in = '0;
                     state_in    = ST_SCAN;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == count_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !dist_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait for the response register to free up, then post the result.
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               if (!anchor_found_ff) begin
                  rsp_first_in   = '0;
                  rsp_partner_in = '0;
                  rsp_alone_in   = 1'b0;
                  rsp_empty_in   = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  pw_en          = 1'b1;
                  rsp_first_in   = OUT_IDX_W'(anchor_idx_ff);
                  rsp_partner_in = partner_found_ff ? OUT_IDX_W'(best_idx_ff)
                                                    : OUT_IDX_W'(anchor_idx_ff);
                  rsp_alone_in   = !partner_found_ff;
                  rsp_empty_in   = 1'b0;
                  state_in       = partner_found_ff ? ST_MARK : ST_IDLE;
               end
            end
         end
         ST_MARK: begin
            pw_en    = 1'b1;
            pw_addr  = best_idx_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         anchor_found_ff  <= 1'b0;
         partner_found_ff <= 1'b0;
         rsp_vld_ff       <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         anchor_found_ff  <= anchor_found_in;
         partner_found_ff <= partner_found_in;
         rsp_vld_ff       <= rsp_vld_in;
      end
      scan_cnt_ff    <= scan_cnt_in;
      anchor_idx_ff  <= anchor_idx_in;
      anc_x_ff       <= anc_x_in;
      anc_y_ff       <= anc_y_in;
      best_idx_ff    <= best_idx_in;
      best_d_ff      <= best_d_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_partner_ff <= rsp_partner_in;
      rsp_alone_ff   <= rsp_alone_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   // Response channel.
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{FILL_W{1'b0}}, rsp_partner_ff, rsp_first_ff};
   assign rsp_tuser  = {rsp_empty_ff, rsp_alone_ff};

   // The count never passes the store size.
   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_POINTS), "point count exceeds store size")
   // Every scan read lies below the count.
   `ASSERT_IMPLIES(a_scan_range, issue, scan_cnt_ff < count_ff, "scan read beyond loaded points")
   // A partner is only ever chosen after an anchor.
   `ASSERT_IMPLIES(a_partner_anchor, partner_found_ff, anchor_found_ff, "partner without anchor")
   // The partner marked is never the anchor itself.
   `ASSERT_IMPLIES(a_mark_distinct, state_ff == ST_MARK, best_idx_ff != anchor_idx_ff, "same index")
   // The result is posted only after the distance pipeline has emptied.
   `ASSERT_IMPLIES(a_finish_drained, state_ff == ST_FINISH, !rd_vld_ff && !dist_busy, "not drained")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import gnp_pkg::*;

   localparam int POINT_CAPACITY  = 8192;
   localparam int COORD_W         = 16;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int SETTLE_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT  = 40000;
   localparam int RANDOM_REQUESTS = 70;

   // The one request code that the package leaves unnamed; the block ignores it.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Expected outcome of one pair request.
   typedef struct {
      logic [OUT_IDX_W-1:0] first_idx;
      logic [OUT_IDX_W-1:0] partner_idx;
      logic                 alone;
      logic                 none_left;
   } pair_outcome_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;        // coord_x [15:0], coord_y [31:16]
   logic [CMD_W-1:0]      req_tuser  = CMD_LOAD;  // cmd [1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;              // first_index [12:0], partner_index [25:13]
   logic [RSP_USER_W-1:0] rsp_tuser;              // alone [0], empty_res [1]

   // Shadow copy of the point store and the pairing map.
   logic [COORD_W-1:0] stored_x [POINT_CAPACITY];
   logic [COORD_W-1:0] stored_y [POINT_CAPACITY];
   bit                 is_matched [POINT_CAPACITY];
   int                 stored_count = 0;
   pair_outcome_type   pending_pairs [$];

   int error_count   = 0;
   int burst_left    = 0;
   bit pacing_on     = 1'b1;
   int rsp_stall_pct = 0;
   bit holdoff_arm   = 1'b0;
   int holdoff_left  = 0;
   int idle_cycles   = 0;

   greedy_nearest_pairing #(
      .MAX_POINTS(POINT_CAPACITY),
      .COORD_BITS(COORD_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted request to the shadow store and queues the pair it produces.
   function automatic void predict_pairing(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] x,
                                           logic [COORD_W-1:0] y);
      pair_outcome_type  outcome;
      int                anchor;
      int                partner;
      longint unsigned   dx;
      longint unsigned   dy;
      longint unsigned   sq_len;
      longint unsigned   best_dist;
      case (cmd)
         CMD_LOAD: begin
            // A full store drops the point.
            if (stored_count < POINT_CAPACITY) begin
               stored_x[stored_count]   = x;
               stored_y[stored_count]   = y;
               is_matched[stored_count] = 1'b0;
               stored_count++;
            end
         end
         CMD_CLEAR: begin
            stored_count = 0;
            foreach (is_matched[i]) is_matched[i] = 1'b0;
         end
         CMD_PAIR: begin
            anchor    = -1;
            partner   = -1;
            best_dist = 0;
            // The first free point is the anchor; the strict compare keeps the lowest index on ties.
            for (int i = 0; i < stored_count; i++) begin
               if (is_matched[i]) continue;
               if (anchor < 0) begin
                  anchor = i;
                  continue;
               end
               dx = (stored_x[anchor] >= stored_x[i]) ? stored_x[anchor] - stored_x[i]
                                                      : stored_x[i] - stored_x[anchor];
               dy = (stored_y[anchor] >= stored_y[i]) ? stored_y[anchor] - stored_y[i]
                                                      : stored_y[i] - stored_y[anchor];
               sq_len = dx * dx + dy * dy;
               if (partner < 0 || sq_len < best_dist) begin
                  best_dist = sq_len;
                  partner   = i;
               end
            end
            outcome = '{default: '0};
            if (anchor < 0) begin
               outcome.none_left = 1'b1;
            end else if (partner < 0) begin
               is_matched[anchor]  = 1'b1;
               outcome.first_idx   = OUT_IDX_W'(anchor);
               outcome.partner_idx = OUT_IDX_W'(anchor);
               outcome.alone       = 1'b1;
            end else begin
               is_matched[anchor]  = 1'b1;
               is_matched[partner] = 1'b1;
               outcome.first_idx   = OUT_IDX_W'(anchor);
               outcome.partner_idx = OUT_IDX_W'(partner);
            end
            pending_pairs = {pending_pairs, outcome};
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [OUT_IDX_W-1:0] want,
                                       logic [OUT_IDX_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Coordinates: a tight cluster for ties, the range corners, or anywhere.
   function automatic logic [COORD_W-1:0] pick_coord(int spread);
      case (spread)
         0: return COORD_W'($urandom_range(0, 7));
         1: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return '1;
               default: return COORD_W'($urandom);
            endcase
         end
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Every accepted request goes through the predictor.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         predict_pairing(req_tuser, req_tdata[15:0], req_tdata[31:16]);
   end

   // Every accepted result is compared with the oldest expected pair.
   always @(posedge clock) begin
      pair_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual first %0d partner %0d alone %0d empty %0d",
                     $time, rsp_tdata[12:0], rsp_tdata[25:13], rsp_tuser[0], rsp_tuser[1]);
            error_count++;
         end else begin
            want = pending_pairs.pop_front();
            check_field("first_index", want.first_idx, rsp_tdata[12:0]);
            check_field("partner_index", want.partner_idx, rsp_tdata[25:13]);
            check_field("alone", OUT_IDX_W'(want.alone), OUT_IDX_W'(rsp_tuser[0]));
            check_field("empty_res", OUT_IDX_W'(want.none_left), OUT_IDX_W'(rsp_tuser[1]));
         end
      end
   end

   // Result receiver: random stalls, or a long hold-off once armed.
   always @(posedge clock) begin
      if (holdoff_arm) begin
         holdoff_arm  = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         rsp_tready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one request and returns at the edge where it is accepted.
   // Requests go out in bursts; a gap between bursts drops tvalid.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] x = '0,
                               logic [COORD_W-1:0] y = '0);
      int gap;
      if (burst_left == 0) begin
         gap = pacing_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering requests until every expected pair has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_pairs.size() != 0);
   endtask

   // Empty store, tie on distance, lone last point, range corners, ignored code, clear.
   task automatic test_directed();
      pacing_on     = 1'b0;
      rsp_stall_pct = 0;
      send_request(CMD_PAIR);
      send_request(CMD_LOAD, 16'd0, 16'd0);
      send_request(CMD_LOAD, 16'hFFFF, 16'hFFFF);
      send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(CMD_LOAD, 16'd3, 16'd4);
      send_request(CMD_LOAD, 16'd4, 16'd3);
      send_request(CMD_LOAD, 16'hFFFF, 16'd0);
      send_request(CMD_PAIR);
      send_request(CMD_PAIR);
      send_request(CMD_PAIR);
      send_request(CMD_PAIR);
      // Two opposite corners: the largest possible distance.
      send_request(CMD_LOAD, 16'd0, 16'hFFFF);
      send_request(CMD_LOAD, 16'hFFFF, 16'd0);
      send_request(CMD_PAIR);
      send_request(CMD_CLEAR);
      send_request(CMD_PAIR);
      send_request(CMD_LOAD, 16'd7, 16'd9);
      send_request(CMD_PAIR);
      wait_for_results();
   endtask

   // The receiver holds off while requests keep coming, so the block must stall its input.
   task automatic test_backpressure();
      pacing_on     = 1'b0;
      rsp_stall_pct = 0;
      send_request(CMD_CLEAR);
      holdoff_arm = 1'b1;
      for (int i = 0; i < 8; i++)
         send_request(CMD_LOAD, pick_coord(2), pick_coord(2));
      for (int i = 0; i < 5; i++)
         send_request(CMD_PAIR);
      send_request(CMD_LOAD, pick_coord(2), pick_coord(2));
      send_request(CMD_PAIR);
      wait_for_results();
   endtask

   // Random load-then-pair sequences with occasional ignored codes and stray requests.
   task automatic test_random_pairing();
      int issued;
      int n_load;
      int n_pair;
      int spread;
      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         pacing_on     = ($urandom_range(0, 3) != 0);
         rsp_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
         spread        = $urandom_range(0, 2);
         if ($urandom_range(0, 3) != 0) begin
            send_request(CMD_CLEAR);
            issued++;
         end
         n_load = $urandom_range(0, 12);
         n_pair = n_load / 2 + $urandom_range(0, 2);
         for (int i = 0; i < n_load; i++) begin
            send_request(CMD_LOAD, pick_coord(spread), pick_coord(spread));
            issued++;
            // Pairing in the middle of loading.
            if ($urandom_range(0, 5) == 0) begin
               send_request(CMD_PAIR);
               issued++;
               n_pair--;
            end
         end
         for (int i = 0; i < n_pair; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_request(CMD_UNUSED, COORD_W'($urandom), COORD_W'($urandom));
            send_request(CMD_PAIR);
            issued++;
         end
         if ($urandom_range(0, 3) == 0)
            wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_pairing();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
